>>> rtl/b64pe_pkg.sv
`timescale 1ns / 1ps

package b64pe_pkg;

    // Field and counter widths
    localparam int CHAR_W          = 8;
    localparam int SYM_W           = 6;
    localparam int NET_W           = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int SAT_W           = 32;

    // Characters with a special meaning
    localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;  // '%'
    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;  // '='
    localparam logic [CHAR_W-1:0] CH_THREE  = 8'h33;  // '3'
    localparam logic [CHAR_W-1:0] CH_TWO    = 8'h32;  // '2'
    localparam logic [CHAR_W-1:0] CH_UP_D   = 8'h44;  // 'D'
    localparam logic [CHAR_W-1:0] CH_UP_B   = 8'h42;  // 'B'
    localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;  // 'F'
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;  // '/'
    localparam logic [CHAR_W-1:0] CASE_MASK = 8'h20;

    // Symbol values of the escaped characters
    localparam logic [SYM_W-1:0] VAL_PLUS  = 6'd62;
    localparam logic [SYM_W-1:0] VAL_SLASH = 6'd63;

    // Escape tracking
    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_PCT,
        ESC_DIGIT
    } t_esc_phase;

    // One classified character, as it travels through the queue
    typedef struct packed {
        logic [SYM_W-1:0] sym_val;
        logic             sym_ok;
        logic             is_eq;
        logic             is_pct;
        logic             dig_three;
        logic             dig_two;
        logic             let_d;
        logic             let_b;
        logic             let_f;
        logic             last;
    } t_sym_class;

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Alphabet lookup: {in_alphabet, value}
    function automatic logic [SYM_W:0] sym_lookup(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        logic              ok;
        v  = '0;
        ok = 1'b1;
        case (c) inside
            [8'h41:8'h5A]: v = c - 8'h41;          // A-Z
            [8'h61:8'h7A]: v = c - 8'h47;          // a-z
            [8'h30:8'h39]: v = c + 8'h04;          // 0-9
            CH_PLUS:       v = 8'(VAL_PLUS);
            CH_SLASH:      v = 8'(VAL_SLASH);
            default:       ok = 1'b0;
        endcase
        return {ok, v[SYM_W-1:0]};
    endfunction

endpackage

>>> rtl/base64_decoder_percent_escapes_core.sv
`timescale 1ns / 1ps
// A character transfer is written into the queue, then decoded from its head into the
// result register. Throughput: one character per cycle while not stalled; the two-entry
// queue between classifier and decode stage absorbs output stalls until it is full.
// Reset: synchronous, active low; clears decode state, queue and output valid.
// No clearing pass is needed after reset.
module base64_decoder_percent_escapes_core #(
    parameter int COUNT_WIDTH = b64pe_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [b64pe_pkg::CHAR_W-1:0] i_symbol_char,
    input  logic                         i_is_final,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_byte_valid,
    output logic [b64pe_pkg::CHAR_W-1:0] o_data_byte,
    output logic                         o_done_res,
    output logic                         o_decode_error,
    output logic [b64pe_pkg::NET_W-1:0]  o_net_length
);

    b64pe_pkg::t_sym_class w_cls_in;
    b64pe_pkg::t_sym_class w_cls_head;
    b64pe_pkg::t_q_status  w_q_status;
    logic                  w_push;
    logic                  w_pop;

    // Front end: accept and classify
    b64pe_front u_front (
        .i_valid       (i_valid),
        .i_symbol_char (i_symbol_char),
        .i_is_final    (i_is_final),
        .i_q_status    (w_q_status),
        .o_stall       (o_stall),
        .o_push        (w_push),
        .o_cls         (w_cls_in)
    );

    // Queue between front and back
    b64pe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wdata  (w_cls_in),
        .i_pop    (w_pop),
        .o_rdata  (w_cls_head),
        .o_status (w_q_status)
    );

    // Back end: decode state and result register
    b64pe_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cls          (w_cls_head),
        .i_avail        (!w_q_status.empty),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_valid   (o_byte_valid),
        .o_data_byte    (o_data_byte),
        .o_done_res     (o_done_res),
        .o_decode_error (o_decode_error),
        .o_net_length   (o_net_length)
    );

    // Queue can never be full and empty at once
    a_q_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue full and empty together");

    // A decoded byte never goes out with the error flag
    a_no_byte_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> !o_decode_error)
        else $error("byte emitted with error flag");

    // Net length only on a clean done result
    a_net_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (!o_done_res || o_decode_error)) |-> (o_net_length == '0))
        else $error("net length outside clean done result");

    // A character transfer into the queue while full must not happen
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> !w_push)
        else $error("push into full queue");

endmodule

>>> rtl/b64pe_front.sv
`timescale 1ns / 1ps

module b64pe_front (
    input  logic                          i_valid,
    input  logic [b64pe_pkg::CHAR_W-1:0]  i_symbol_char,
    input  logic                          i_is_final,
    input  b64pe_pkg::t_q_status          i_q_status,
    output logic                          o_stall,
    output logic                          o_push,
    output b64pe_pkg::t_sym_class         o_cls
);

    logic [b64pe_pkg::SYM_W:0]  look;
    logic [b64pe_pkg::CHAR_W-1:0] upper;

    // Stall only while the queue is full
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // Classify the character for every state the back end may be in
    always_comb begin
        look  = b64pe_pkg::sym_lookup(i_symbol_char);
        upper = i_symbol_char & ~b64pe_pkg::CASE_MASK;
        o_cls.sym_val   = look[b64pe_pkg::SYM_W-1:0];
        o_cls.sym_ok    = look[b64pe_pkg::SYM_W];
        o_cls.is_eq     = (i_symbol_char == b64pe_pkg::CH_EQ);
        o_cls.is_pct    = (i_symbol_char == b64pe_pkg::CH_PCT);
        o_cls.dig_three = (i_symbol_char == b64pe_pkg::CH_THREE);
        o_cls.dig_two   = (i_symbol_char == b64pe_pkg::CH_TWO);
        o_cls.let_d     = (upper == b64pe_pkg::CH_UP_D);
        o_cls.let_b     = (upper == b64pe_pkg::CH_UP_B);
        o_cls.let_f     = (upper == b64pe_pkg::CH_UP_F);
        o_cls.last      = i_is_final;
    end

endmodule

>>> rtl/b64pe_queue.sv
`timescale 1ns / 1ps

module b64pe_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b64pe_pkg::t_sym_class i_wdata,
    input  logic                  i_pop,
    output b64pe_pkg::t_sym_class o_rdata,
    output b64pe_pkg::t_q_status  o_status
);

    // Two-entry queue
    b64pe_pkg::t_sym_class r_mem [2];
    logic                  r_wptr;
    logic                  r_rptr;
    logic [1:0]            r_count;
    logic [1:0]            n_count;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign o_rdata        = r_mem[r_rptr];

    always_comb begin
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_wdata;
    end

endmodule

>>> rtl/b64pe_back.sv
`timescale 1ns / 1ps

module b64pe_back #(
    parameter int COUNT_WIDTH = b64pe_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  b64pe_pkg::t_sym_class        i_cls,
    input  logic                         i_avail,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_byte_valid,
    output logic [b64pe_pkg::CHAR_W-1:0] o_data_byte,
    output logic                         o_done_res,
    output logic                         o_decode_error,
    output logic [b64pe_pkg::NET_W-1:0]  o_net_length
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Decoder state
    logic [1:0]                       r_pos,    n_pos;
    logic [b64pe_pkg::SYM_W-1:0]      r_carry,  n_carry;
    b64pe_pkg::t_esc_phase            r_phase,  n_phase;
    logic                             r_d3,     n_d3;
    logic [COUNT_WIDTH-1:0]           r_bytes,  n_bytes;
    logic [COUNT_WIDTH-1:0]           r_pad,    n_pad;
    logic                             r_failed, n_failed;

    // Output register
    logic                             r_out_valid;
    logic                             r_byte_valid;
    logic [b64pe_pkg::CHAR_W-1:0]     r_data_byte;
    logic                             r_done;
    logic                             r_err;
    logic [b64pe_pkg::NET_W-1:0]      r_net;

    // Per-item results
    logic                             take;
    logic [b64pe_pkg::SYM_W-1:0]      take_v;
    logic                             take_pad;
    logic                             emit;
    logic [b64pe_pkg::CHAR_W-1:0]     res_byte;
    logic                             res_err;
    logic [b64pe_pkg::NET_W-1:0]      res_net;
    logic [COUNT_WIDTH-1:0]           diff;
    logic [b64pe_pkg::SAT_W-1:0]      diff_ext;
    logic                             load;

    // Output register loads when empty or being drained
    assign load    = !r_out_valid || !i_stall;
    assign o_pop   = i_avail && load;
    assign o_valid = r_out_valid;

    assign o_byte_valid   = r_byte_valid;
    assign o_data_byte    = r_data_byte;
    assign o_done_res     = r_done;
    assign o_decode_error = r_err;
    assign o_net_length   = r_net;

    // Next state and result for the item at the head of the queue
    always_comb begin
        n_pos    = r_pos;
        n_carry  = r_carry;
        n_phase  = r_phase;
        n_d3     = r_d3;
        n_bytes  = r_bytes;
        n_pad    = r_pad;
        n_failed = r_failed;
        take     = 1'b0;
        take_v   = '0;
        take_pad = 1'b0;
        emit     = 1'b0;
        res_byte = '0;
        res_net  = '0;
        diff     = '0;
        diff_ext = '0;

        // Escape tracking and symbol selection
        if (!r_failed) begin
            case (r_phase)
                b64pe_pkg::ESC_IDLE: begin
                    if (i_cls.is_pct) begin
                        n_phase = b64pe_pkg::ESC_PCT;
                    end else if (i_cls.is_eq) begin
                        take     = 1'b1;
                        take_pad = 1'b1;
                    end else if (i_cls.sym_ok) begin
                        take   = 1'b1;
                        take_v = i_cls.sym_val;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                b64pe_pkg::ESC_PCT: begin
                    if (i_cls.dig_three) begin
                        n_d3    = 1'b1;
                        n_phase = b64pe_pkg::ESC_DIGIT;
                    end else if (i_cls.dig_two) begin
                        n_d3    = 1'b0;
                        n_phase = b64pe_pkg::ESC_DIGIT;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                b64pe_pkg::ESC_DIGIT: begin
                    n_phase = b64pe_pkg::ESC_IDLE;
                    if (r_d3 && i_cls.let_d) begin
                        take     = 1'b1;
                        take_pad = 1'b1;
                    end else if (!r_d3 && i_cls.let_b) begin
                        take   = 1'b1;
                        take_v = b64pe_pkg::VAL_PLUS;
                    end else if (!r_d3 && i_cls.let_f) begin
                        take   = 1'b1;
                        take_v = b64pe_pkg::VAL_SLASH;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    n_phase = b64pe_pkg::ESC_IDLE;
                end
            endcase
        end

        // Symbol into the current group of four
        if (take) begin
            case (r_pos)
                2'd0: begin
                    n_carry = take_v;
                end
                2'd1: begin
                    emit     = 1'b1;
                    res_byte = {r_carry, take_v[5:4]};
                    n_carry  = {2'b00, take_v[3:0]};
                end
                2'd2: begin
                    emit     = 1'b1;
                    res_byte = {r_carry[3:0], take_v[5:2]};
                    n_carry  = {4'b0000, take_v[1:0]};
                end
                default: begin
                    emit     = 1'b1;
                    res_byte = {r_carry[1:0], take_v};
                    n_carry  = '0;
                end
            endcase
            // Padding count over the last two positions
            if (r_pos[1]) begin
                if (!take_pad)            n_pad = '0;
                else if (r_pad != CNT_MAX) n_pad = r_pad + 1'b1;
            end
            n_pos = r_pos + 2'd1;
        end

        // Truncated message
        if (i_cls.last && !n_failed &&
            (n_phase != b64pe_pkg::ESC_IDLE || n_pos != 2'd0)) begin
            n_failed = 1'b1;
        end

        if (n_failed) emit = 1'b0;
        if (!emit)    res_byte = '0;
        if (emit && r_bytes != CNT_MAX) n_bytes = r_bytes + 1'b1;
        res_err = n_failed;

        // Net length on a clean end of message
        if (i_cls.last && !n_failed) begin
            if (n_bytes > n_pad) diff = n_bytes - n_pad;
            diff_ext = b64pe_pkg::SAT_W'(diff);
            if (diff_ext > b64pe_pkg::SAT_W'(16'hFFFF)) res_net = 16'hFFFF;
            else                                        res_net = diff_ext[15:0];
        end

        // Fresh state for the next message
        if (i_cls.last) begin
            n_pos    = 2'd0;
            n_carry  = '0;
            n_phase  = b64pe_pkg::ESC_IDLE;
            n_d3     = 1'b0;
            n_bytes  = '0;
            n_pad    = '0;
            n_failed = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 2'd0;
            r_carry  <= '0;
            r_phase  <= b64pe_pkg::ESC_IDLE;
            r_d3     <= 1'b0;
            r_bytes  <= '0;
            r_pad    <= '0;
            r_failed <= 1'b0;
        end else if (o_pop) begin
            r_pos    <= n_pos;
            r_carry  <= n_carry;
            r_phase  <= n_phase;
            r_d3     <= n_d3;
            r_bytes  <= n_bytes;
            r_pad    <= n_pad;
            r_failed <= n_failed;
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_avail;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte_valid <= emit;
            r_data_byte  <= res_byte;
            r_done       <= i_cls.last;
            r_err        <= res_err;
            r_net        <= res_net;
        end
    end

endmodule
